FILE: hdl/msq_pkg.sv
// Shared types and constants of the multilevel queue scheduler.
`timescale 1ns / 1ps
package msq_pkg;

	localparam int NUM_QUEUES    = 3;
	localparam int DEF_SLOTS     = 16;
	localparam int DEF_TIME_BITS = 16;
	localparam int CFG_IDX_W     = 3;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_TOP_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MID_LOW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MID_HIGH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_LOW  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_HIGH = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SLICE    = 3'd7;

	localparam logic [3:0] RST_TOP_LOW  = 4'd7;
	localparam logic [3:0] RST_TOP_HIGH = 4'd9;
	localparam logic [3:0] RST_MID_LOW  = 4'd4;
	localparam logic [3:0] RST_MID_HIGH = 4'd6;
	localparam logic [3:0] RST_LOW_LOW  = 4'd1;
	localparam logic [3:0] RST_LOW_HIGH = 4'd3;
	localparam logic [7:0] RST_QUANTUM  = 8'd4;
	localparam logic [7:0] RST_SLICE    = 8'd10;

	localparam logic [1:0] Q_RR   = 2'd0;
	localparam logic [1:0] Q_PRIO = 2'd1;
	localparam logic [1:0] Q_FCFS = 2'd2;

	typedef struct packed {
		logic       operation;
		logic [3:0] priority_req;
		logic [7:0] burst;
	} cmd_item_t;

	typedef struct packed {
		logic        accepted;
		logic        ran;
		logic [1:0]  queue_id;
		logic [3:0]  slot;
		logic        finished;
		logic [15:0] turnaround;
		logic [15:0] waiting;
		logic        all_done;
	} rsp_item_t;

endpackage

FILE: hdl/msq_if.sv
// Handshake channel interfaces of the multilevel queue scheduler.
`timescale 1ns / 1ps
interface msq_cmd_if import msq_pkg::*;;
	logic      valid;
	logic      ready;
	cmd_item_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface msq_rsp_if import msq_pkg::*;;
	logic      valid;
	logic      ready;
	rsp_item_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface msq_cfg_if import msq_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [7:0]           data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/multilevel_queue_scheduler.sv
// Multilevel queue scheduler: three queues, slot memory, scan and sweep sequencer.
//
//  channel | dir | payload                                   | accepted when
//  cmd     | in  | operation, priority_req, burst            | cmd.valid && cmd.ready
//  rsp     | out | accepted, ran, queue_id, slot, finished,  | rsp.valid && rsp.ready
//          |     | turnaround, waiting, all_done             |
//  cfg     | in  | index, data                               | cfg.valid && cfg.ready
//
// An add is handled in IDLE. A tick served from queue 1 or 2 passes through SCAN, SWEEP and DONE:
// the slot scan over the fill of the served queue (one memory read a cycle), then the aging
// sweep over all slots of all queues through the single memory port.
// Queue 0 adds a check of the current slot (RR_CHK, RR_EVAL) and skips the scan while that slot
// keeps running. An idle tick is answered from IDLE. cmd.ready is low while an item is in work
// or its result waits on rsp. Reset clears queue fills and the scheduling state; slot
// contents are valid only below the fill of their queue.
`timescale 1ns / 1ps
module multilevel_queue_scheduler import msq_pkg::*; #(
	parameter int SLOTS_PER_QUEUE = DEF_SLOTS,
	parameter int TIME_BITS       = DEF_TIME_BITS
) (
	input logic      clk,
	input logic      arst_n,
	msq_cmd_if.sink  cmd,
	msq_rsp_if.source rsp,
	msq_cfg_if.sink  cfg
);

	localparam int SW    = $clog2(SLOTS_PER_QUEUE);
	localparam int FW    = $clog2(SLOTS_PER_QUEUE + 1);
	localparam int CW    = FW + 2;
	localparam int DEPTH = NUM_QUEUES * SLOTS_PER_QUEUE;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_RR_CHK  = 3'd1;
	localparam logic [2:0] ST_RR_EVAL = 3'd2;
	localparam logic [2:0] ST_SCAN    = 3'd3;
	localparam logic [2:0] ST_SWEEP   = 3'd4;
	localparam logic [2:0] ST_DONE    = 3'd5;

	typedef struct packed {
		logic [3:0]           prio;
		logic [7:0]           rem;
		logic [7:0]           burst;
		logic [TIME_BITS-1:0] age;
	} entry_t;

	function automatic logic [AW-1:0] addr_of(input logic [1:0] q, input logic [SW-1:0] s);
		addr_of = AW'(AW'(q) * AW'(SLOTS_PER_QUEUE) + AW'(s));
	endfunction

	function automatic logic [SW-1:0] next_idx(input logic [SW-1:0] i,
			input logic [FW-1:0] f, input logic wrap_en);
		logic [FW-1:0] inc;
		inc = FW'(i) + FW'(1);
		next_idx = (wrap_en && inc >= f) ? '0 : SW'(inc);
	endfunction

	// configuration
	logic [3:0] top_lo_q, top_hi_q, mid_lo_q, mid_hi_q, low_lo_q, low_hi_q;
	logic [7:0] quantum_ticks_q, slice_ticks_q;

	// scheduling state
	logic [2:0]    state_q;
	logic [FW-1:0] fill_q [NUM_QUEUES];
	logic [FW-1:0] cnt_q [NUM_QUEUES];
	logic [1:0]    aq_q;
	logic [7:0]    slice_q;
	logic [7:0]    quantum_q;
	logic [SW-1:0] rr_q;

	// per-tick work registers
	logic [1:0]    q_q;
	logic [SW-1:0] idx_q, chosen_q;
	logic [FW-1:0] left_q;
	logic          found_q, have_q;
	logic [3:0]    best_prio_q;
	logic          sc_v_s1;
	logic [SW-1:0] j_s1;
	logic [1:0]    sq_q;
	logic [SW-1:0] ss_q;
	logic          sw_done_q;
	logic          sw_v_s1, inwin_s1, chosen_s1;
	logic [AW-1:0] wa_s1;
	logic          fin_q;
	logic [TIME_BITS-1:0] tat_q;
	logic [7:0]    burst_q;

	logic      rsp_valid_q;
	rsp_item_t rsp_item_q;

	// slot memory
	entry_t        mem [DEPTH];
	entry_t        rd_q;
	logic [AW-1:0] rd_addr, wa;
	entry_t        wd;
	logic          we;

	logic [NUM_QUEUES-1:0] has;
	logic                  cmd_acc;
	logic [7:0]            eff_q, eff_s;
	logic                  in_top, in_mid, in_low, matched, room;
	logic [1:0]            mq;
	logic [1:0]            n1, n2, new_aq;
	logic                  rotate;
	logic                  issue;
	entry_t                wb;
	logic [TIME_BITS-1:0]  wt_full;
	logic [15:0]           tat_sat, wt_sat;
	logic                  last_pending;

	assign cmd.ready = (state_q == ST_IDLE) && !rsp_valid_q;
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.item  = rsp_item_q;
	assign cmd_acc   = cmd.valid && cmd.ready;

	always_comb begin
		for (int k = 0; k < NUM_QUEUES; k++) has[k] = cnt_q[k] != '0;
	end

	assign eff_q = (quantum_ticks_q == 8'd0) ? 8'd1 : quantum_ticks_q;
	assign eff_s = (slice_ticks_q == 8'd0) ? 8'd1 : slice_ticks_q;

	// band match, lowest queue wins
	assign in_top  = top_lo_q <= cmd.item.priority_req && cmd.item.priority_req <= top_hi_q;
	assign in_mid  = mid_lo_q <= cmd.item.priority_req && cmd.item.priority_req <= mid_hi_q;
	assign in_low  = low_lo_q <= cmd.item.priority_req && cmd.item.priority_req <= low_hi_q;
	assign matched = in_top || in_mid || in_low;
	assign mq      = in_top ? Q_RR : (in_mid ? Q_PRIO : Q_FCFS);
	assign room    = matched && (fill_q[mq] < FW'(SLOTS_PER_QUEUE));

	// rotation: next queue with work, current one last
	assign n1     = (aq_q == Q_FCFS) ? Q_RR : aq_q + 2'd1;
	assign n2     = (n1 == Q_FCFS) ? Q_RR : n1 + 2'd1;
	assign rotate = (slice_q >= eff_s) || !has[aq_q];
	always_comb begin
		new_aq = aq_q;
		if (rotate) begin
			if (has[n1]) new_aq = n1;
			else if (has[n2]) new_aq = n2;
		end
	end

	assign issue = (state_q == ST_SCAN) && (left_q != '0) && !found_q;

	always_comb begin
		case (state_q)
			ST_RR_CHK: rd_addr = addr_of(Q_RR, rr_q);
			ST_SCAN:   rd_addr = addr_of(q_q, idx_q);
			ST_SWEEP:  rd_addr = addr_of(sq_q, ss_q);
			default:   rd_addr = '0;
		endcase
	end

	// sweep writeback: age every pending slot, run the chosen one
	always_comb begin
		wb = rd_q;
		if (rd_q.rem != 8'd0 && rd_q.age != TIME_MAX) wb.age = rd_q.age + TIME_BITS'(1);
		if (chosen_s1) wb.rem = rd_q.rem - 8'd1;
	end

	always_comb begin
		if (cmd_acc && cmd.item.operation == OP_ADD) begin
			we = room;
			wa = addr_of(mq, SW'(fill_q[mq]));
			wd = '{prio: cmd.item.priority_req, rem: cmd.item.burst,
				burst: cmd.item.burst, age: '0};
		end else begin
			we = sw_v_s1 && inwin_s1;
			wa = wa_s1;
			wd = wb;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (we) mem[wa] <= wd;
	end

	assign wt_full = (tat_q > TIME_BITS'(burst_q)) ? tat_q - TIME_BITS'(burst_q) : '0;
	assign tat_sat = (tat_q > TIME_BITS'(16'hFFFF)) ? 16'hFFFF : 16'(tat_q);
	assign wt_sat  = (wt_full > TIME_BITS'(16'hFFFF)) ? 16'hFFFF : 16'(wt_full);
	assign last_pending = (CW'(cnt_q[0]) + CW'(cnt_q[1]) + CW'(cnt_q[2])) == CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_lo_q        <= RST_TOP_LOW;
			top_hi_q        <= RST_TOP_HIGH;
			mid_lo_q        <= RST_MID_LOW;
			mid_hi_q        <= RST_MID_HIGH;
			low_lo_q        <= RST_LOW_LOW;
			low_hi_q        <= RST_LOW_HIGH;
			quantum_ticks_q <= RST_QUANTUM;
			slice_ticks_q   <= RST_SLICE;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_TOP_LOW:  top_lo_q        <= cfg.data[3:0];
				CFG_TOP_HIGH: top_hi_q        <= cfg.data[3:0];
				CFG_MID_LOW:  mid_lo_q        <= cfg.data[3:0];
				CFG_MID_HIGH: mid_hi_q        <= cfg.data[3:0];
				CFG_LOW_LOW:  low_lo_q        <= cfg.data[3:0];
				CFG_LOW_HIGH: low_hi_q        <= cfg.data[3:0];
				CFG_QUANTUM:  quantum_ticks_q <= cfg.data;
				CFG_SLICE:    slice_ticks_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// scan and sweep datapath registers
	always_ff @(posedge clk) begin
		sc_v_s1   <= issue;
		j_s1      <= idx_q;
		wa_s1     <= addr_of(sq_q, ss_q);
		inwin_s1  <= FW'(ss_q) < fill_q[sq_q];
		chosen_s1 <= (sq_q == q_q) && (ss_q == chosen_q);
		if (sw_v_s1 && inwin_s1 && chosen_s1) begin
			fin_q   <= rd_q.rem == 8'd1;
			tat_q   <= wb.age;
			burst_q <= rd_q.burst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			for (int k = 0; k < NUM_QUEUES; k++) begin
				fill_q[k] <= '0;
				cnt_q[k]  <= '0;
			end
			aq_q        <= Q_RR;
			slice_q     <= '0;
			quantum_q   <= RST_QUANTUM;
			rr_q        <= '0;
			q_q         <= Q_RR;
			idx_q       <= '0;
			chosen_q    <= '0;
			left_q      <= '0;
			found_q     <= 1'b0;
			have_q      <= 1'b0;
			best_prio_q <= '0;
			sq_q        <= '0;
			ss_q        <= '0;
			sw_done_q   <= 1'b0;
			sw_v_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_item_q  <= '0;
		end else begin
			sw_v_s1 <= (state_q == ST_SWEEP) && !sw_done_q;
			if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						if (cmd.item.operation == OP_ADD) begin
							rsp_valid_q <= 1'b1;
							rsp_item_q  <= '{accepted: room, ran: 1'b0,
								queue_id: matched ? mq : Q_RR,
								slot: room ? 4'(fill_q[mq]) : 4'd0,
								finished: 1'b0, turnaround: '0, waiting: '0,
								all_done: !((|has) || (room && cmd.item.burst != 8'd0))};
							if (room) begin
								fill_q[mq] <= fill_q[mq] + FW'(1);
								if (cmd.item.burst != 8'd0) cnt_q[mq] <= cnt_q[mq] + FW'(1);
							end
						end else if (!(|has)) begin
							rsp_valid_q <= 1'b1;
							rsp_item_q  <= '{all_done: 1'b1, default: '0};
						end else begin
							aq_q <= new_aq;
							q_q  <= new_aq;
							if (rotate) slice_q <= '0;
							idx_q     <= '0;
							left_q    <= fill_q[new_aq];
							found_q   <= 1'b0;
							have_q    <= 1'b0;
							sq_q      <= '0;
							ss_q      <= '0;
							sw_done_q <= 1'b0;
							state_q   <= (new_aq == Q_RR) ? ST_RR_CHK : ST_SCAN;
						end
					end
				end
				ST_RR_CHK: state_q <= ST_RR_EVAL;
				ST_RR_EVAL: begin
					// keep the current process while it has work and quantum
					if (quantum_q != 8'd0 && FW'(rr_q) < fill_q[Q_RR] && rd_q.rem != 8'd0) begin
						chosen_q <= rr_q;
						state_q  <= ST_SWEEP;
					end else begin
						idx_q   <= next_idx(rr_q, fill_q[Q_RR], 1'b1);
						left_q  <= fill_q[Q_RR];
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						idx_q  <= next_idx(idx_q, fill_q[q_q], q_q == Q_RR);
						left_q <= left_q - FW'(1);
					end
					if (sc_v_s1 && !found_q && rd_q.rem != 8'd0) begin
						if (q_q == Q_PRIO) begin
							if (!have_q || rd_q.prio > best_prio_q) begin
								chosen_q    <= j_s1;
								best_prio_q <= rd_q.prio;
								have_q      <= 1'b1;
							end
						end else begin
							found_q  <= 1'b1;
							chosen_q <= j_s1;
							if (q_q == Q_RR) begin
								rr_q      <= j_s1;
								quantum_q <= eff_q;
							end
						end
					end
					if (found_q || (left_q == '0 && !sc_v_s1)) state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					if (sw_done_q) begin
						state_q <= ST_DONE;
					end else if (ss_q == SW'(SLOTS_PER_QUEUE - 1)) begin
						ss_q <= '0;
						if (sq_q == Q_FCFS) sw_done_q <= 1'b1;
						else sq_q <= sq_q + 2'd1;
					end else begin
						ss_q <= ss_q + SW'(1);
					end
				end
				ST_DONE: begin
					rsp_valid_q <= 1'b1;
					rsp_item_q  <= '{accepted: 1'b0, ran: 1'b1, queue_id: q_q,
						slot: 4'(chosen_q), finished: fin_q,
						turnaround: fin_q ? tat_sat : 16'd0,
						waiting: fin_q ? wt_sat : 16'd0,
						all_done: fin_q && last_pending};
					if (fin_q) cnt_q[q_q] <= cnt_q[q_q] - FW'(1);
					slice_q <= slice_q + 8'd1;
					if (q_q == Q_RR && quantum_q != 8'd0) quantum_q <= quantum_q - 8'd1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_busy_blocks_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE || rsp_valid_q) |-> !cmd.ready)
		else $error("command taken while busy");
	a_finish_implies_ran: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.item.finished) |-> (rsp.item.ran && !rsp.item.accepted))
		else $error("finish reported without a run");
	a_pending_le_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q[0] <= fill_q[0]) && (cnt_q[1] <= fill_q[1]) && (cnt_q[2] <= fill_q[2]))
		else $error("pending count exceeds fill");
	a_done_reports: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> rsp.valid)
		else $error("tick result lost");

endmodule

FILE: tb/sv/msq_sched_checker.sv
// Watches the scheduler channels, predicts every response and compares it.
`timescale 1ns / 1ps
module msq_sched_checker import msq_pkg::*; #(
	parameter int SLOTS = DEF_SLOTS
) (
	input logic clk,
	input logic arst_n,
	msq_cmd_if  cmd,
	msq_rsp_if  rsp,
	msq_cfg_if  cfg,
	output int  errors,
	output int  pending
);
	localparam int TOTAL   = NUM_QUEUES * SLOTS;
	localparam int AGE_MAX = 65535;

	logic [3:0] band_lo [NUM_QUEUES];
	logic [3:0] band_hi [NUM_QUEUES];
	logic [7:0] quantum;
	logic [7:0] slice_len;
	logic [3:0] slot_prio [TOTAL];
	logic [7:0] slot_left [TOTAL];
	logic [7:0] slot_len [TOTAL];
	int         slot_age [TOTAL];
	int         fill [NUM_QUEUES];
	int         served_q;
	int         slice_used;
	int         quantum_left;
	int         rr_pos;
	rsp_item_t  expected_rsp [$];

	function automatic bit queue_busy(int q);
		for (int j = 0; j < fill[q]; j++)
			if (slot_left[q * SLOTS + j] != 0) return 1;
		return 0;
	endfunction

	function automatic bit work_left();
		for (int q = 0; q < NUM_QUEUES; q++)
			if (queue_busy(q)) return 1;
		return 0;
	endfunction

	function automatic int choose_slot(int q);
		int best;
		bit found;
		best = 0;
		found = 0;
		if (q == Q_RR) begin
			if (quantum_left == 0 || rr_pos >= fill[0] || slot_left[rr_pos] == 0) begin
				for (int k = 1; k <= fill[0]; k++) begin
					if (slot_left[(rr_pos + k) % fill[0]] != 0) begin
						rr_pos = (rr_pos + k) % fill[0];
						quantum_left = (quantum == 0) ? 1 : quantum;
						break;
					end
				end
			end
			return rr_pos;
		end
		for (int j = 0; j < fill[q]; j++) begin
			if (slot_left[q * SLOTS + j] == 0) continue;
			if (q == Q_FCFS) return j;
			if (!found || slot_prio[q * SLOTS + j] > slot_prio[q * SLOTS + best]) begin
				best = j;
				found = 1;
			end
		end
		return best;
	endfunction

	function automatic rsp_item_t schedule_step(cmd_item_t c);
		rsp_item_t r;
		int q, s, b, tat, wt, slice_eff;
		r = '0;
		if (c.operation == OP_ADD) begin
			q = -1;
			for (int k = NUM_QUEUES - 1; k >= 0; k--)
				if (band_lo[k] <= c.priority_req && c.priority_req <= band_hi[k]) q = k;
			if (q >= 0) begin
				r.queue_id = q[1:0];
				if (fill[q] < SLOTS) begin
					b = q * SLOTS + fill[q];
					slot_prio[b] = c.priority_req;
					slot_left[b] = c.burst;
					slot_len[b] = c.burst;
					slot_age[b] = 0;
					r.accepted = 1;
					r.slot = fill[q][3:0];
					fill[q]++;
				end
			end
			r.all_done = !work_left();
			return r;
		end
		if (!work_left()) begin
			r.all_done = 1;
			return r;
		end
		slice_eff = (slice_len == 0) ? 1 : slice_len;
		if (slice_used >= slice_eff || !queue_busy(served_q)) begin
			for (int i = 1; i <= NUM_QUEUES; i++) begin
				if (queue_busy((served_q + i) % NUM_QUEUES)) begin
					served_q = (served_q + i) % NUM_QUEUES;
					break;
				end
			end
			slice_used = 0;
		end
		q = served_q;
		s = choose_slot(q);
		b = q * SLOTS + s;
		for (int i = 0; i < TOTAL; i++)
			if (i < NUM_QUEUES * SLOTS && (i % SLOTS) < fill[i / SLOTS] &&
					slot_left[i] != 0 && slot_age[i] < AGE_MAX)
				slot_age[i]++;
		slot_left[b]--;
		slice_used++;
		if (q == Q_RR && quantum_left > 0) quantum_left--;
		r.ran = 1;
		r.queue_id = q[1:0];
		r.slot = s[3:0];
		if (slot_left[b] == 0) begin
			tat = slot_age[b];
			wt = (tat > slot_len[b]) ? tat - slot_len[b] : 0;
			r.finished = 1;
			r.turnaround = tat[15:0];
			r.waiting = wt[15:0];
		end
		r.all_done = !work_left();
		return r;
	endfunction

	task automatic report(string field, int exp_v, int got_v);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, got_v);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_item_t e, g;
		if (!arst_n) begin
			band_lo = '{RST_TOP_LOW, RST_MID_LOW, RST_LOW_LOW};
			band_hi = '{RST_TOP_HIGH, RST_MID_HIGH, RST_LOW_HIGH};
			quantum = RST_QUANTUM;
			slice_len = RST_SLICE;
			fill = '{0, 0, 0};
			for (int i = 0; i < TOTAL; i++) begin
				slot_left[i] = 0;
				slot_age[i] = 0;
			end
			served_q = 0;
			slice_used = 0;
			quantum_left = RST_QUANTUM;
			rr_pos = 0;
			expected_rsp.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_TOP_LOW:  band_lo[0] = cfg.data[3:0];
					CFG_TOP_HIGH: band_hi[0] = cfg.data[3:0];
					CFG_MID_LOW:  band_lo[1] = cfg.data[3:0];
					CFG_MID_HIGH: band_hi[1] = cfg.data[3:0];
					CFG_LOW_LOW:  band_lo[2] = cfg.data[3:0];
					CFG_LOW_HIGH: band_hi[2] = cfg.data[3:0];
					CFG_QUANTUM:  quantum = cfg.data;
					CFG_SLICE:    slice_len = cfg.data;
					default: ;
				endcase
			end
			if (cmd.valid && cmd.ready)
				expected_rsp.push_back(schedule_step(cmd.item));
			if (rsp.valid && rsp.ready) begin
				g = rsp.item;
				if (expected_rsp.size() == 0) begin
					$display("%0t: unexpected response, expected none, actual %h", $time, g);
					errors++;
				end else begin
					e = expected_rsp.pop_front();
					if (g.accepted !== e.accepted) report("accepted", e.accepted, g.accepted);
					if (g.ran !== e.ran) report("ran", e.ran, g.ran);
					if (g.queue_id !== e.queue_id) report("queue_id", e.queue_id, g.queue_id);
					if (g.slot !== e.slot) report("slot", e.slot, g.slot);
					if (g.finished !== e.finished) report("finished", e.finished, g.finished);
					if (g.turnaround !== e.turnaround)
						report("turnaround", e.turnaround, g.turnaround);
					if (g.waiting !== e.waiting) report("waiting", e.waiting, g.waiting);
					if (g.all_done !== e.all_done) report("all_done", e.all_done, g.all_done);
				end
			end
			pending = expected_rsp.size();
		end
	end
endmodule

FILE: tb/sv/multilevel_queue_scheduler_tb.sv
// Stimulus and verdict for the multilevel queue scheduler.
`timescale 1ns / 1ps
module multilevel_queue_scheduler_tb import msq_pkg::*;;
	logic clk;
	logic arst_n;
	bit   gaps_on;
	int   errors;
	int   pending;
	int   item_count;
	int   tick_count;

	msq_cmd_if cmd ();
	msq_rsp_if rsp ();
	msq_cfg_if cfg ();

	multilevel_queue_scheduler DUT (.clk(clk), .arst_n(arst_n), .cmd(cmd), .rsp(rsp), .cfg(cfg));

	msq_sched_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .rsp(rsp), .cfg(cfg),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

	always @(posedge clk)
		rsp.ready <= gaps_on ? ($urandom_range(99) >= 30) : 1'b1;

	// valid stays high across back-to-back items; drop it only for a gap
	task automatic send_item(logic op, logic [3:0] prio, logic [7:0] len);
		if (gaps_on && $urandom_range(99) < 30) begin
			cmd.valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		cmd.valid <= 1;
		cmd.item <= '{operation: op, priority_req: prio, burst: len};
		do @(posedge clk); while (!cmd.ready);
		item_count++;
		if (op == OP_TICK) tick_count++;
	endtask

	task automatic drain();
		cmd.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
	endtask

	task automatic program_all(logic [3:0] tl, th, ml, mh, ll, lh, logic [7:0] qt, sl);
		write_reg(CFG_TOP_LOW, tl);
		write_reg(CFG_TOP_HIGH, th);
		write_reg(CFG_MID_LOW, ml);
		write_reg(CFG_MID_HIGH, mh);
		write_reg(CFG_LOW_LOW, ll);
		write_reg(CFG_LOW_HIGH, lh);
		write_reg(CFG_QUANTUM, qt);
		write_reg(CFG_SLICE, sl);
		cfg.valid <= 0;
		@(posedge clk);
	endtask

	// random traffic; mostly short bursts so processes finish, a few long ones
	task automatic random_phase(int n, int add_pct);
		logic [7:0] len;
		for (int i = 0; i < n; i++) begin
			gaps_on = !(i >= n / 3 && i < n / 2);
			if ($urandom_range(99) < add_pct) begin
				case ($urandom_range(9))
					0: len = 8'($urandom_range(255));
					1: len = 8'd0;
					2: len = 8'hFF;
					default: len = 8'($urandom_range(1, 6));
				endcase
				send_item(OP_ADD, 4'($urandom_range(15)), len);
			end else begin
				send_item(OP_TICK, 4'($urandom_range(15)), 8'($urandom_range(255)));
			end
		end
		drain();
	endtask

	initial begin
		arst_n = 0;
		gaps_on = 1;
		item_count = 0;
		tick_count = 0;
		cmd.valid = 0;
		cmd.item = '0;
		rsp.ready = 0;
		cfg.valid = 0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: idle tick, out-of-band priorities, each queue, zero burst
		send_item(OP_TICK, 4'd0, 8'd0);
		send_item(OP_ADD, 4'd0, 8'd5);
		send_item(OP_ADD, 4'd15, 8'd5);
		send_item(OP_ADD, 4'd8, 8'd3);
		send_item(OP_ADD, 4'd9, 8'd2);
		send_item(OP_ADD, 4'd5, 8'd2);
		send_item(OP_ADD, 4'd6, 8'd2);
		send_item(OP_ADD, 4'd4, 8'd1);
		send_item(OP_ADD, 4'd2, 8'd0);
		send_item(OP_ADD, 4'd1, 8'd3);
		send_item(OP_ADD, 4'd3, 8'd1);
		repeat (14) send_item(OP_TICK, 4'd15, 8'hFF);
		drain();

		// overlapping full bands, quantum and slice at their smallest
		program_all(4'd0, 4'd15, 4'd0, 4'd15, 4'd0, 4'd15, 8'd0, 8'd0);
		random_phase(200, 35);
		program_all(4'd10, 4'd15, 4'd5, 4'd9, 4'd0, 4'd4, 8'd1, 8'd1);
		random_phase(250, 40);
		// empty top band, largest quantum and slice
		program_all(4'd15, 4'd0, 4'd8, 4'd15, 4'd0, 4'd7, 8'd255, 8'd255);
		random_phase(250, 40);
		program_all(4'($urandom_range(15)), 4'($urandom_range(15)), 4'($urandom_range(15)),
			4'($urandom_range(15)), 4'($urandom_range(15)), 4'($urandom_range(15)),
			8'($urandom_range(1, 8)), 8'($urandom_range(1, 12)));
		random_phase(350, 30);
		program_all(RST_TOP_LOW, RST_TOP_HIGH, RST_MID_LOW, RST_MID_HIGH,
			RST_LOW_LOW, RST_LOW_HIGH, 8'd3, 8'd7);
		random_phase(375, 15);

		repeat (200) @(posedge clk);
		$display("Ran %0d items (%0d ticks) over six register settings,", item_count, tick_count);
		$display("covering band overlap, empty bands, full queues and quantum/slice extremes.");
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

FILE: multilevel_queue_scheduler.f
hdl/msq_pkg.sv
hdl/msq_if.sv
hdl/multilevel_queue_scheduler.sv
tb/sv/msq_sched_checker.sv
tb/sv/multilevel_queue_scheduler_tb.sv
